/* rtl/core/scharr_gradient_normal_map_unit_assert.svh */
// Assertion macros shared by the gradient unit modules.
// Each macro expects signals named clk and rst_n in the enclosing module.
`ifndef SCHARR_GRADIENT_NORMAL_MAP_UNIT_ASSERT_SVH
`define SCHARR_GRADIENT_NORMAL_MAP_UNIT_ASSERT_SVH

// The expression must hold at every clock edge out of reset.
`define SGNM_ASSERT_ALWAYS(label, expr, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
        else $error(msg);

// The consequent must hold in the same cycle as the antecedent.
`define SGNM_ASSERT_IMPLY(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

`endif

/* rtl/core/sgnm_pkg.sv */
package sgnm_pkg;

    localparam int MAX_WIDTH  = 1024;
    localparam int MAX_HEIGHT = 1024;
    localparam int FRAC_W     = 4;

    localparam int SAMPLE_W = 16;
    localparam int DIM_W    = 11;
    localparam int COL_W    = $clog2(MAX_WIDTH);
    localparam int ROW_W    = $clog2(MAX_HEIGHT);
    localparam int CODE_W   = 8;
    localparam int GRAD_W   = 22;
    localparam int CFG_IDX_W = 2;

    localparam int TQ_DEPTH = 4;
    localparam int TQ_PTR_W = $clog2(TQ_DEPTH);
    localparam int TQ_CNT_W = TQ_PTR_W + 1;

    localparam int OQ_DEPTH = 4;
    localparam int OQ_PTR_W = $clog2(OQ_DEPTH);
    localparam int OQ_CNT_W = OQ_PTR_W + 1;

    localparam int TRUNC_BIAS = (1 << FRAC_W) - 1;

    localparam logic [CODE_W-1:0]    NZ_CODE          = CODE_W'(125);
    localparam logic [CFG_IDX_W-1:0] CFG_FRAME_WIDTH  = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] CFG_FRAME_HEIGHT = CFG_IDX_W'(1);

    typedef logic signed [SAMPLE_W-1:0] sample_t;
    typedef sample_t [8:0] window_t;

    // One output pixel's neighborhood plus where it sits in the frame.
    typedef struct packed {
        window_t win;
        logic    top_mirror;
        logic    left_mirror;
        logic    last_row;
        logic    last_col;
    } task_t;

    typedef struct packed {
        logic [TQ_CNT_W-1:0] count;
        logic                empty;
    } tq_status_t;

    typedef struct packed {
        logic [CODE_W-1:0] grad_x;
        logic [CODE_W-1:0] grad_y;
        logic              frame_done;
        logic              step_last;
    } out_item_t;

    typedef enum logic [1:0] {
        VAR_BASE,
        VAR_ROW,
        VAR_COL,
        VAR_CORNER
    } variant_t;

    // Truncate toward zero to an integer, then add the code offset modulo 256.
    function automatic logic [CODE_W-1:0] grad_code(input logic signed [GRAD_W-1:0] g);
        logic signed [GRAD_W-1:0] biased;
        logic signed [GRAD_W-1:0] whole;
        biased = g + (g[GRAD_W-1] ? GRAD_W'(TRUNC_BIAS) : GRAD_W'(0));
        whole  = biased >>> FRAC_W;
        return whole[CODE_W-1:0] + NZ_CODE;
    endfunction

endpackage

/* rtl/core/sgnm_front.sv */
`include "scharr_gradient_normal_map_unit_assert.svh"

module sgnm_front
    import sgnm_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 push,
    output logic                 full,
    input  sample_t              depth_sample,
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [DIM_W-1:0]     cfg_data,
    input  tq_status_t           tq_status,
    output logic                 tq_push,
    output task_t                tq_data
);

    typedef struct packed {
        logic emit;
        logic top_mirror;
        logic left_mirror;
        logic last_row;
        logic last_col;
    } pos_info_t;

    // Each entry holds {older row, newer row} for one column.
    logic [2*SAMPLE_W-1:0] line_mem [MAX_WIDTH];
    logic [2*SAMPLE_W-1:0] line_rd_reg;

    logic [DIM_W-1:0] frame_width_reg, frame_width_next;
    logic [DIM_W-1:0] frame_height_reg, frame_height_next;
    logic [COL_W-1:0] col_count_reg, col_count_next;
    logic [ROW_W-1:0] row_count_reg, row_count_next;

    logic             s1_valid_reg;
    sample_t          s1_sample_reg;
    logic [COL_W-1:0] s1_col_reg;
    pos_info_t        s1_info_reg;

    window_t   window_reg, window_next;
    pos_info_t pos_info;
    logic      in_accept;
    logic      cfg_fire;
    logic      cfg_hit;
    logic [TQ_CNT_W:0] tq_claimed;

    function automatic logic [DIM_W-1:0] clamp_dim(input logic [DIM_W-1:0] v,
                                                   input logic [DIM_W-1:0] hi);
        logic [DIM_W-1:0] r;
        r = v;
        if (v < DIM_W'(2))
        begin
            r = DIM_W'(2);
        end
        else if (v > hi)
        begin
            r = hi;
        end
        return r;
    endfunction

    // Room is reserved for the item still in the second stage.
    assign tq_claimed = (TQ_CNT_W + 1)'(tq_status.count) + (TQ_CNT_W + 1)'(s1_valid_reg);
    assign full       = tq_claimed >= (TQ_CNT_W + 1)'(TQ_DEPTH);
    assign in_accept  = push && !full;
    assign cfg_ready  = 1'b1;
    assign cfg_fire   = cfg_valid && cfg_ready;
    assign cfg_hit    = cfg_fire
                        && (cfg_index == CFG_FRAME_WIDTH || cfg_index == CFG_FRAME_HEIGHT);

    always_comb
    begin
        pos_info.emit        = (row_count_reg != '0) && (col_count_reg != '0);
        pos_info.top_mirror  = row_count_reg == ROW_W'(1);
        pos_info.left_mirror = col_count_reg == COL_W'(1);
        pos_info.last_row    = (DIM_W'(row_count_reg) + DIM_W'(1)) >= frame_height_reg;
        pos_info.last_col    = (DIM_W'(col_count_reg) + DIM_W'(1)) >= frame_width_reg;
    end

    always_comb
    begin
        frame_width_next  = frame_width_reg;
        frame_height_next = frame_height_reg;
        col_count_next    = col_count_reg;
        row_count_next    = row_count_reg;
        if (cfg_fire && cfg_index == CFG_FRAME_WIDTH)
        begin
            frame_width_next = clamp_dim(cfg_data, DIM_W'(MAX_WIDTH));
        end
        if (cfg_fire && cfg_index == CFG_FRAME_HEIGHT)
        begin
            frame_height_next = clamp_dim(cfg_data, DIM_W'(MAX_HEIGHT));
        end
        if (cfg_hit)
        begin
            col_count_next = '0;
            row_count_next = '0;
        end
        else if (in_accept)
        begin
            if (pos_info.last_col)
            begin
                col_count_next = '0;
                row_count_next = pos_info.last_row ? '0 : row_count_reg + ROW_W'(1);
            end
            else
            begin
                col_count_next = col_count_reg + COL_W'(1);
            end
        end
    end

    always_comb
    begin
        window_next = window_reg;
        if (s1_valid_reg)
        begin
            for (int i = 0; i < 3; i++)
            begin
                window_next[i*3 + 0] = window_reg[i*3 + 1];
                window_next[i*3 + 1] = window_reg[i*3 + 2];
            end
            window_next[2] = line_rd_reg[2*SAMPLE_W-1:SAMPLE_W];
            window_next[5] = line_rd_reg[SAMPLE_W-1:0];
            window_next[8] = s1_sample_reg;
        end
    end

    assign tq_push          = s1_valid_reg && s1_info_reg.emit;
    assign tq_data.win      = window_next;
    assign tq_data.top_mirror  = s1_info_reg.top_mirror;
    assign tq_data.left_mirror = s1_info_reg.left_mirror;
    assign tq_data.last_row = s1_info_reg.last_row;
    assign tq_data.last_col = s1_info_reg.last_col;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            frame_width_reg  <= DIM_W'(MAX_WIDTH);
            frame_height_reg <= DIM_W'(MAX_HEIGHT);
            col_count_reg    <= '0;
            row_count_reg    <= '0;
            s1_valid_reg     <= 1'b0;
            window_reg       <= '0;
        end
        else
        begin
            frame_width_reg  <= frame_width_next;
            frame_height_reg <= frame_height_next;
            col_count_reg    <= col_count_next;
            row_count_reg    <= row_count_next;
            s1_valid_reg     <= in_accept;
            window_reg       <= window_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            s1_sample_reg <= depth_sample;
            s1_col_reg    <= col_count_reg;
            s1_info_reg   <= pos_info;
        end
    end

    // Read happens at acceptance, the rotated column is written back in the following cycle.
    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            line_rd_reg <= line_mem[col_count_reg];
        end
        if (s1_valid_reg)
        begin
            line_mem[s1_col_reg] <= {line_rd_reg[SAMPLE_W-1:0], s1_sample_reg};
        end
    end

    `SGNM_ASSERT_ALWAYS(a_col_in_frame, DIM_W'(col_count_reg) < frame_width_reg, "column position outside frame")
    `SGNM_ASSERT_IMPLY(a_stage_has_room, s1_valid_reg, tq_status.count != TQ_CNT_W'(TQ_DEPTH), "task queue full with item in flight")

endmodule

/* rtl/core/sgnm_task_queue.sv */
`include "scharr_gradient_normal_map_unit_assert.svh"

module sgnm_task_queue
    import sgnm_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       wr_en,
    input  task_t      wr_data,
    input  logic       rd_en,
    output task_t      rd_data,
    output tq_status_t status
);

    task_t               entry_reg [TQ_DEPTH];
    logic [TQ_PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [TQ_PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [TQ_CNT_W-1:0] count_reg, count_next;
    logic                do_rd;

    assign do_rd        = rd_en && (count_reg != '0);
    assign rd_data      = entry_reg[rd_ptr_reg];
    assign status.count = count_reg;
    assign status.empty = count_reg == '0;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg + TQ_PTR_W'(wr_en);
        rd_ptr_next = rd_ptr_reg + TQ_PTR_W'(do_rd);
        count_next  = count_reg + TQ_CNT_W'(wr_en) - TQ_CNT_W'(do_rd);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            entry_reg[wr_ptr_reg] <= wr_data;
        end
    end

    `SGNM_ASSERT_ALWAYS(a_tq_count_bound, count_reg <= TQ_CNT_W'(TQ_DEPTH), "task queue count beyond depth")

endmodule

/* rtl/core/sgnm_back.sv */
`include "scharr_gradient_normal_map_unit_assert.svh"

module sgnm_back
    import sgnm_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  task_t             head,
    input  tq_status_t        tq_status,
    output logic              tq_pop,
    output logic              empty,
    input  logic              pop,
    output logic [CODE_W-1:0] grad_x_code,
    output logic [CODE_W-1:0] grad_y_code,
    output logic              frame_done,
    output logic              step_last
);

    variant_t var_reg, var_next;

    out_item_t           oq_reg [OQ_DEPTH];
    logic [OQ_PTR_W-1:0] oq_wr_ptr_reg, oq_wr_ptr_next;
    logic [OQ_PTR_W-1:0] oq_rd_ptr_reg, oq_rd_ptr_next;
    logic [OQ_CNT_W-1:0] oq_count_reg, oq_count_next;

    logic      fire;
    logic      final_var;
    logic      oq_pop;
    logic [1:0] tr, mr, br, lc, cc, rc;
    out_item_t result;

    function automatic sample_t tap(input window_t w, input logic [1:0] row,
                                    input logic [1:0] col);
        logic [3:0] idx;
        idx = 4'(row) * 4'd3 + 4'(col);
        return w[idx];
    endfunction

    function automatic logic signed [GRAD_W-1:0] diff(input sample_t a, input sample_t b);
        logic signed [GRAD_W-1:0] wa;
        logic signed [GRAD_W-1:0] wb;
        wa = GRAD_W'(a);
        wb = GRAD_W'(b);
        return wa - wb;
    endfunction

    // 3*outer_a + 10*center + 3*outer_b, with shifts and adds.
    function automatic logic signed [GRAD_W-1:0] scharr_sum(
        input logic signed [GRAD_W-1:0] outer_a,
        input logic signed [GRAD_W-1:0] center,
        input logic signed [GRAD_W-1:0] outer_b);
        logic signed [GRAD_W-1:0] outer;
        outer = outer_a + outer_b;
        return (outer <<< 1) + outer + (center <<< 3) + (center <<< 1);
    endfunction

    assign fire = !tq_status.empty && (oq_count_reg != OQ_CNT_W'(OQ_DEPTH));

    // Next variant of the current task.
    always_comb
    begin
        var_next = var_reg;
        if (fire)
        begin
            unique case (var_reg)
                VAR_BASE:
                begin
                    if (head.last_row)
                    begin
                        var_next = VAR_ROW;
                    end
                    else if (head.last_col)
                    begin
                        var_next = VAR_COL;
                    end
                end
                VAR_ROW:
                begin
                    var_next = head.last_col ? VAR_COL : VAR_BASE;
                end
                VAR_COL:
                begin
                    var_next = head.last_row ? VAR_CORNER : VAR_BASE;
                end
                VAR_CORNER:
                begin
                    var_next = VAR_BASE;
                end
                default:
                begin
                    var_next = VAR_BASE;
                end
            endcase
        end
    end

    // Tap selection and task retirement for the current variant.
    always_comb
    begin
        tr = head.top_mirror ? 2'd2 : 2'd0;
        mr = 2'd1;
        br = 2'd2;
        lc = head.left_mirror ? 2'd2 : 2'd0;
        cc = 2'd1;
        rc = 2'd2;
        final_var = 1'b1;
        unique case (var_reg)
            VAR_BASE:
            begin
                final_var = !head.last_row && !head.last_col;
            end
            VAR_ROW:
            begin
                tr = 2'd1;
                mr = 2'd2;
                br = 2'd1;
                final_var = !head.last_col;
            end
            VAR_COL:
            begin
                lc = 2'd1;
                cc = 2'd2;
                rc = 2'd1;
                final_var = !head.last_row;
            end
            VAR_CORNER:
            begin
                tr = 2'd1;
                mr = 2'd2;
                br = 2'd1;
                lc = 2'd1;
                cc = 2'd2;
                rc = 2'd1;
                final_var = 1'b1;
            end
            default:
            begin
                final_var = 1'b1;
            end
        endcase
        tq_pop = fire && final_var;
    end

    always_comb
    begin
        result.grad_x = grad_code(scharr_sum(
            diff(tap(head.win, tr, rc), tap(head.win, tr, lc)),
            diff(tap(head.win, mr, rc), tap(head.win, mr, lc)),
            diff(tap(head.win, br, rc), tap(head.win, br, lc))));
        result.grad_y = grad_code(scharr_sum(
            diff(tap(head.win, br, lc), tap(head.win, tr, lc)),
            diff(tap(head.win, br, cc), tap(head.win, tr, cc)),
            diff(tap(head.win, br, rc), tap(head.win, tr, rc))));
        result.frame_done = (var_reg == VAR_CORNER) || (var_reg == VAR_COL && final_var
                            && head.last_row) || (final_var && head.last_row && head.last_col);
        result.step_last  = final_var;
    end

    assign oq_pop = pop && !empty;

    always_comb
    begin
        oq_wr_ptr_next = oq_wr_ptr_reg + OQ_PTR_W'(fire);
        oq_rd_ptr_next = oq_rd_ptr_reg + OQ_PTR_W'(oq_pop);
        oq_count_next  = oq_count_reg + OQ_CNT_W'(fire) - OQ_CNT_W'(oq_pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            var_reg       <= VAR_BASE;
            oq_wr_ptr_reg <= '0;
            oq_rd_ptr_reg <= '0;
            oq_count_reg  <= '0;
        end
        else
        begin
            var_reg       <= var_next;
            oq_wr_ptr_reg <= oq_wr_ptr_next;
            oq_rd_ptr_reg <= oq_rd_ptr_next;
            oq_count_reg  <= oq_count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (fire)
        begin
            oq_reg[oq_wr_ptr_reg] <= result;
        end
    end

    assign empty       = oq_count_reg == '0;
    assign grad_x_code = oq_reg[oq_rd_ptr_reg].grad_x;
    assign grad_y_code = oq_reg[oq_rd_ptr_reg].grad_y;
    assign frame_done  = oq_reg[oq_rd_ptr_reg].frame_done;
    assign step_last   = oq_reg[oq_rd_ptr_reg].step_last;

    `SGNM_ASSERT_IMPLY(a_done_is_last, fire && result.frame_done, result.step_last, "frame end not on last result of item")
    `SGNM_ASSERT_IMPLY(a_task_held, var_reg != VAR_BASE, !tq_status.empty, "task left the queue mid sequence")

endmodule

/* rtl/core/scharr_gradient_normal_map_unit.sv */
// Streaming 3x3 Scharr gradient unit. Depth samples enter in raster order, one
// per cycle, and results leave in raster order one row and one column behind,
// with reflect-101 mirroring at every border. Items in rows and columns past
// the first give one result each, two in the last column or the last row, and
// the frame's last item gives four. The input side takes one item per cycle as
// long as the four-entry task queue has room; the result side writes one result
// per cycle into a four-entry output queue while it has room, so in the last
// row, where each item gives two results or more, the pace is set by that
// single result writer. On the way out, the line store is read when an item is
// accepted, the window update then writes the task queue, and the output queue
// is written after that. Both previous rows live in one line store with one
// read and one write port per cycle. Writes to frame_width or frame_height are
// clamped to 2..1024 and restart the frame position, and must be made while no
// item is in flight.
module scharr_gradient_normal_map_unit
    import sgnm_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 push,
    output logic                 full,
    input  logic signed [15:0]   depth_sample,
    output logic                 empty,
    input  logic                 pop,
    output logic [7:0]           grad_x_code,
    output logic [7:0]           grad_y_code,
    output logic [7:0]           normal_z_code,
    output logic                 frame_done,
    output logic                 step_last,
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [DIM_W-1:0]     cfg_data
);

    tq_status_t tq_status;
    logic       tq_push;
    logic       tq_pop;
    task_t      tq_wr_data;
    task_t      tq_head;

    sgnm_front u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .push         (push),
        .full         (full),
        .depth_sample (depth_sample),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .tq_status    (tq_status),
        .tq_push      (tq_push),
        .tq_data      (tq_wr_data)
    );

    sgnm_task_queue u_task_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (tq_push),
        .wr_data (tq_wr_data),
        .rd_en   (tq_pop),
        .rd_data (tq_head),
        .status  (tq_status)
    );

    sgnm_back u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .head        (tq_head),
        .tq_status   (tq_status),
        .tq_pop      (tq_pop),
        .empty       (empty),
        .pop         (pop),
        .grad_x_code (grad_x_code),
        .grad_y_code (grad_y_code),
        .frame_done  (frame_done),
        .step_last   (step_last)
    );

    assign normal_z_code = NZ_CODE;

endmodule

/* dv/scharr_gradient_normal_map_unit_tb.sv */
`timescale 1ns / 100ps

module scharr_gradient_normal_map_unit_tb
    import sgnm_pkg::*;
();

    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_A = CFG_IDX_W'(2);
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_B = CFG_IDX_W'(3);
    localparam int SETTLE_CYCLES  = 12;
    localparam int LONG_STALL     = 80;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int RANDOM_ITEMS   = 24;

    typedef struct {
        logic [CODE_W-1:0] gx;
        logic [CODE_W-1:0] gy;
        logic [CODE_W-1:0] nz;
        logic              done;
        logic              last;
    } grad_result_t;

    // Tracks the line stores, window and frame position to predict the gradient
    // codes of each depth item, and checks the results in order.
    class gradient_predictor;
        sample_t      older_row[MAX_WIDTH];
        sample_t      newer_row[MAX_WIDTH];
        sample_t      win[9];
        int unsigned  row_pos;
        int unsigned  col_pos;
        int unsigned  width;
        int unsigned  height;
        grad_result_t pending_codes[$];
        int unsigned  bad_results;
        int unsigned  seen_results;

        function new();
            foreach (older_row[i])
            begin
                older_row[i] = '0;
                newer_row[i] = '0;
            end
            foreach (win[i])
                win[i] = '0;
            row_pos = 0;
            col_pos = 0;
            width = MAX_WIDTH;
            height = MAX_HEIGHT;
            bad_results = 0;
            seen_results = 0;
        endfunction

        function void write_register(logic [CFG_IDX_W-1:0] idx, logic [DIM_W-1:0] value);
            int unsigned v;
            v = value;
            if (v < 2)
                v = 2;
            if (idx == CFG_FRAME_WIDTH)
                width = (v > MAX_WIDTH) ? MAX_WIDTH : v;
            else if (idx == CFG_FRAME_HEIGHT)
                height = (v > MAX_HEIGHT) ? MAX_HEIGHT : v;
            else
                return;
            row_pos = 0;
            col_pos = 0;
        endfunction

        function int tap(int r, int c);
            return int'(win[r * 3 + c]);
        endfunction

        function logic [CODE_W-1:0] code_of(int g);
            int whole;
            whole = g / (1 << FRAC_W);
            return CODE_W'(whole) + NZ_CODE;
        endfunction

        // Window rows tr/mr/br and columns lc/cc/rc select the mirrored neighborhood.
        function void add_pixel(int tr, int mr, int br, int lc, int cc, int rc, bit done);
            grad_result_t res;
            int gx;
            int gy;
            gx = 3 * (tap(tr, rc) - tap(tr, lc)) + 10 * (tap(mr, rc) - tap(mr, lc))
               + 3 * (tap(br, rc) - tap(br, lc));
            gy = 3 * (tap(br, lc) - tap(tr, lc)) + 10 * (tap(br, cc) - tap(tr, cc))
               + 3 * (tap(br, rc) - tap(tr, rc));
            res.gx = code_of(gx);
            res.gy = code_of(gy);
            res.nz = NZ_CODE;
            res.done = done;
            res.last = 1'b0;
            pending_codes.push_back(res);
        endfunction

        function void take_sample(sample_t s);
            int unsigned r;
            int unsigned c;
            int          top;
            int          left;
            int          i;
            bit          last_col;
            bit          last_row;
            r = row_pos;
            c = col_pos;
            if (c >= MAX_WIDTH)
                c = 0;
            for (i = 0; i < 3; i++)
            begin
                win[i * 3]     = win[i * 3 + 1];
                win[i * 3 + 1] = win[i * 3 + 2];
            end
            win[2] = older_row[c];
            win[5] = newer_row[c];
            win[8] = s;
            older_row[c] = newer_row[c];
            newer_row[c] = s;
            last_col = (c + 1 >= width);
            last_row = (r + 1 >= height);
            if (r >= 1 && c >= 1)
            begin
                top = (r == 1) ? 2 : 0;
                left = (c == 1) ? 2 : 0;
                add_pixel(top, 1, 2, left, 1, 2, 1'b0);
                if (last_row)
                    add_pixel(1, 2, 1, left, 1, 2, 1'b0);
                if (last_col)
                begin
                    add_pixel(top, 1, 2, 1, 2, 1, 1'b0);
                    if (last_row)
                        add_pixel(1, 2, 1, 1, 2, 1, 1'b1);
                end
                pending_codes[pending_codes.size() - 1].last = 1'b1;
            end
            if (last_col)
            begin
                col_pos = 0;
                row_pos = last_row ? 0 : r + 1;
            end
            else
            begin
                col_pos = c + 1;
            end
        endfunction

        function void check_result(grad_result_t got);
            grad_result_t want;
            seen_results++;
            if (pending_codes.size() == 0)
            begin
                bad_results++;
                if (bad_results <= 10)
                    $display("result %0d arrived with nothing expected", seen_results);
                return;
            end
            want = pending_codes.pop_front();
            if (got.gx !== want.gx || got.gy !== want.gy || got.nz !== want.nz
                || got.done !== want.done || got.last !== want.last)
            begin
                bad_results++;
                if (bad_results <= 10)
                begin
                    $display("result %0d: expected x=%0d y=%0d z=%0d done=%b last=%b",
                             seen_results, want.gx, want.gy, want.nz, want.done, want.last);
                    $display("result %0d: got      x=%0d y=%0d z=%0d done=%b last=%b",
                             seen_results, got.gx, got.gy, got.nz, got.done, got.last);
                end
            end
        endfunction

        function int unsigned pending();
            return pending_codes.size();
        endfunction
    endclass

    logic                 clk;
    logic                 rst_n;
    logic                 push;
    logic                 full;
    sample_t              depth_sample;
    logic                 empty;
    logic                 pop;
    logic [7:0]           grad_x_code;
    logic [7:0]           grad_y_code;
    logic [7:0]           normal_z_code;
    logic                 frame_done;
    logic                 step_last;
    logic                 cfg_valid;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [DIM_W-1:0]     cfg_data;

    gradient_predictor predictor = new();
    sample_t           stim_q[$];
    bit                stall_request = 1'b0;
    int unsigned       quiet_cycles = 0;

    scharr_gradient_normal_map_unit uut (
        .clk           (clk),
        .rst_n         (rst_n),
        .push          (push),
        .full          (full),
        .depth_sample  (depth_sample),
        .empty         (empty),
        .pop           (pop),
        .grad_x_code   (grad_x_code),
        .grad_y_code   (grad_y_code),
        .normal_z_code (normal_z_code),
        .frame_done    (frame_done),
        .step_last     (step_last),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    function automatic sample_t any_depth();
        case ($urandom_range(0, 9))
            0:       return $urandom_range(0, 1) ? 16'sh7FFF : 16'sh8000;
            1, 2, 3: return sample_t'($urandom);
            default: return sample_t'($urandom_range(0, 400)) - sample_t'(200);
        endcase
    endfunction

    task automatic fill_random(input int unsigned n);
        stim_q.delete();
        repeat (n)
            stim_q.push_back(any_depth());
    endtask

    task automatic offer_sample(input sample_t value);
        push <= 1'b1;
        depth_sample <= value;
        do
            @(posedge clk);
        while (full);
        predictor.take_sample(value);
        @(negedge clk);
    endtask

    // Sends the queued items in bursts of random length, with an occasional
    // stream that runs without any gaps.
    task automatic send_stream();
        int unsigned burst;
        int unsigned gap;
        int unsigned k;
        bit          dense;
        burst = 0;
        dense = ($urandom_range(0, 3) == 0);
        for (k = 0; k < stim_q.size(); k++)
        begin
            if (burst == 0)
            begin
                burst = $urandom_range(1, 16);
                gap = dense ? 0 : $urandom_range(0, 6);
                if (gap > 0 && k > 0)
                begin
                    push <= 1'b0;
                    repeat (gap)
                        @(negedge clk);
                end
            end
            burst--;
            offer_sample(stim_q[k]);
        end
        push <= 1'b0;
    endtask

    // Items in the first row or column give no result, so a further wait of SETTLE_CYCLES
    // lets the last of them leave the pipeline before the block counts as idle.
    task automatic wait_idle();
        while (predictor.pending() != 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES)
            @(negedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [DIM_W-1:0] value);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= value;
        do
            @(posedge clk);
        while (!cfg_ready);
        predictor.write_register(idx, value);
        @(negedge clk);
        cfg_valid <= 1'b0;
        @(negedge clk);
    endtask

    task automatic set_frame(input logic [DIM_W-1:0] w, input logic [DIM_W-1:0] h);
        write_reg(CFG_FRAME_WIDTH, w);
        write_reg(CFG_FRAME_HEIGHT, h);
    endtask

    initial
    begin : result_side
        int unsigned mode;
        int unsigned span;
        bit          stall_taken;
        mode = 0;
        span = 0;
        stall_taken = 1'b0;
        pop = 1'b0;
        forever
        begin
            @(negedge clk);
            if (stall_request && !stall_taken)
            begin
                stall_taken = 1'b1;
                pop <= 1'b0;
                repeat (LONG_STALL - 1)
                    @(negedge clk);
            end
            else
            begin
                if (span == 0)
                begin
                    mode = $urandom_range(0, 2);
                    span = $urandom_range(8, 40);
                end
                span--;
                case (mode)
                    0:       pop <= 1'b1;
                    1:       pop <= ($urandom_range(0, 3) != 0);
                    default: pop <= ($urandom_range(0, 3) == 0);
                endcase
            end
        end
    end

    always @(posedge clk)
    begin
        grad_result_t got;
        if (rst_n && pop && !empty)
        begin
            got.gx = grad_x_code;
            got.gy = grad_y_code;
            got.nz = normal_z_code;
            got.done = frame_done;
            got.last = step_last;
            predictor.check_result(got);
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n || (push && !full) || (pop && !empty) || (cfg_valid && cfg_ready))
        begin
            quiet_cycles <= 0;
        end
        else if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("scharr_gradient_normal_map_unit: mismatch");
            $finish;
        end
        else
        begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial
    begin : stimulus
        int unsigned random_items;
        int unsigned w;
        int unsigned h;
        int unsigned n;
        rst_n = 1'b0;
        push = 1'b0;
        depth_sample = '0;
        cfg_valid = 1'b0;
        cfg_index = CFG_FRAME_WIDTH;
        cfg_data = '0;
        repeat (5)
            @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Reset size: the start of the first row, which gives no result.
        fill_random(6);
        send_stream();
        wait_idle();

        // Register values below the range clamp to the smallest frame.
        write_reg(CFG_FRAME_WIDTH, DIM_W'(0));
        write_reg(CFG_FRAME_HEIGHT, DIM_W'(1));
        stim_q = {16'sh7FFF, 16'sh8000, 16'sh8000, 16'sh7FFF};
        send_stream();
        wait_idle();

        // Small values exercise truncation toward zero on both signs.
        set_frame(3, 3);
        stim_q = {-16'sd1, 16'sd1, 16'sd16, -16'sd16, 16'sd17, -16'sd17,
                  16'sh7FFF, 16'sh8000, 16'sd0};
        send_stream();
        wait_idle();

        // Writes to unused indexes must not disturb the frame position.
        set_frame(3, 2);
        fill_random(2);
        send_stream();
        wait_idle();
        write_reg(CFG_SPARE_A, DIM_W'(2047));
        write_reg(CFG_SPARE_B, DIM_W'(0));
        fill_random(4);
        send_stream();
        wait_idle();

        // A size write in the middle of a frame restarts it.
        set_frame(2, 3);
        fill_random(3);
        send_stream();
        wait_idle();
        write_reg(CFG_FRAME_HEIGHT, DIM_W'(2));
        fill_random(4);
        send_stream();
        wait_idle();

        // Values above the range clamp to the largest size; only the start of
        // such frames is sent.
        set_frame(DIM_W'(1025), DIM_W'(2));
        fill_random(4);
        send_stream();
        wait_idle();
        set_frame(DIM_W'(2), DIM_W'(2047));
        fill_random(8);
        send_stream();
        wait_idle();

        // The result side holds off long enough for the input to back up.
        set_frame(6, 4);
        stall_request = 1'b1;
        fill_random(24);
        send_stream();
        wait_idle();

        random_items = 0;
        while (random_items < RANDOM_ITEMS)
        begin
            if ($urandom_range(0, 4) == 0)
            begin
                // Raw register values and a frame cut short.
                set_frame(DIM_W'($urandom), DIM_W'($urandom));
                n = $urandom_range(1, 24);
            end
            else
            begin
                w = $urandom_range(2, 9);
                h = $urandom_range(2, 6);
                set_frame(DIM_W'(w), DIM_W'(h));
                n = w * h;
            end
            fill_random(n);
            send_stream();
            wait_idle();
            random_items += n;
        end

        if (predictor.bad_results == 0 && predictor.pending() == 0)
            $display("scharr_gradient_normal_map_unit: match");
        else
            $display("scharr_gradient_normal_map_unit: mismatch");
        $finish;
    end

endmodule
